### rtl/core/tbe_pkg.sv
// ----------------------------------------------------------------------------
// Threshold bitmap encoder package
// Shared widths, group constants and the beat types passed between the
// classifier, the group packer and the queues.
// ----------------------------------------------------------------------------
package tbe_pkg;

	localparam int DATA_W     = 32;
	localparam int THR_W      = 31;
	localparam int POS_W      = 4;
	localparam int IDX_W      = 20;
	localparam int CNT_W      = 25;
	localparam int GROUP_BITS = 16;
	localparam int WORD_W     = 2 * GROUP_BITS;
	localparam int GROUP_SIZE = 16;

	localparam logic [THR_W-1:0] THR_RESET = 31'd66;
	localparam logic [CNT_W-1:0] MAX_FLAGS = 25'd16777216;

	typedef struct packed {
		logic signed [DATA_W-1:0] residual;
		logic                     flag;
		logic                     sign;
		logic                     last;
	} class_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] residual;
		logic                     word_valid;
		logic [WORD_W-1:0]        packed_word;
		logic [IDX_W-1:0]         word_index;
		logic [CNT_W-1:0]         flagged_count;
	} result_t;

endpackage

### rtl/core/tbe_fifo.sv
// ----------------------------------------------------------------------------
// Show-ahead queue
// Small circular buffer of flop entries; the head beat is visible while
// empty is low. Write and read may happen in the same cycle.
// ----------------------------------------------------------------------------
module tbe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/tbe_front.sv
// ----------------------------------------------------------------------------
// Threshold bitmap encoder classifier
// Holds the threshold register and sorts each value into flagged, sign-only
// or pass-through, producing its residual.
// ----------------------------------------------------------------------------
module tbe_front
	import tbe_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [THR_W-1:0]         cfg_threshold,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	output class_t                   item
);

	logic [THR_W-1:0]  thr_q;
	logic [DATA_W-1:0] raw;
	logic [DATA_W-1:0] mag;
	logic [DATA_W-1:0] thr_ext;
	logic [DATA_W-1:0] half_ext;
	logic              neg;
	logic              ge_thr;
	logic              ge_half;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_threshold;
		end
	end

	always_comb begin
		raw      = value;
		neg      = raw[DATA_W-1];
		mag      = neg ? (DATA_W'(0) - raw) : raw;
		thr_ext  = {1'b0, thr_q};
		half_ext = {2'b00, thr_q[THR_W-1:1]};
		ge_thr   = (mag >= thr_ext);
		ge_half  = (mag >= half_ext);

		item.last = last;
		priority if (ge_thr) begin
			item.flag     = 1'b1;
			item.sign     = neg;
			item.residual = neg ? (raw + thr_ext) : (raw - thr_ext);
		end else if (neg && ge_half) begin
			item.flag     = 1'b0;
			item.sign     = 1'b1;
			item.residual = raw + half_ext;
		end else begin
			item.flag     = 1'b0;
			item.sign     = 1'b0;
			item.residual = raw;
		end
	end

endmodule

### rtl/core/tbe_back.sv
// ----------------------------------------------------------------------------
// Threshold bitmap encoder group packer
// Keeps the group bitmap, position, word index and flag count, and builds
// one result beat per classified beat.
// ----------------------------------------------------------------------------
module tbe_back
	import tbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  class_t  item,
	output result_t result
);

	logic [WORD_W-1:0]     bits_q;
	logic [POS_W-1:0]      pos_q;
	logic [IDX_W-1:0]      word_q;
	logic [CNT_W-1:0]      total_q;
	logic [GROUP_BITS-1:0] pos_hot;
	logic [WORD_W-1:0]     bits_next;
	logic [CNT_W-1:0]      total_next;
	logic [POS_W:0]        pos_inc;
	logic                  emit;

	always_comb begin
		pos_hot   = GROUP_BITS'(1) << pos_q;
		bits_next = bits_q | {(item.sign ? pos_hot : '0), (item.flag ? pos_hot : '0)};

		total_next = total_q;
		if ((item.flag || item.sign) && (total_q < MAX_FLAGS)) begin
			total_next = total_q + 1'b1;
		end

		pos_inc = {1'b0, pos_q} + 1'b1;
		emit    = item.last || (pos_inc >= (POS_W + 1)'(GROUP_SIZE));

		result.residual      = item.residual;
		result.word_valid    = emit;
		result.packed_word   = emit ? bits_next : '0;
		result.word_index    = emit ? word_q : '0;
		result.flagged_count = total_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			pos_q   <= '0;
			word_q  <= '0;
			total_q <= '0;
		end else if (fire) begin
			if (emit) begin
				bits_q <= '0;
				pos_q  <= '0;
			end else begin
				bits_q <= bits_next;
				pos_q  <= pos_inc[POS_W-1:0];
			end
			if (item.last) begin
				word_q  <= '0;
				total_q <= '0;
			end else begin
				word_q  <= emit ? word_q + 1'b1 : word_q;
				total_q <= total_next;
			end
		end
	end

endmodule

### rtl/core/threshold_bitmap_encoder.sv
// ----------------------------------------------------------------------------
// Threshold bitmap encoder
// Streams signed Q16.16 values, returns residuals and packed group bitmaps.
// ----------------------------------------------------------------------------
// Input side is a queue: a beat (value, last) is taken when push is high
// and full is low. Result side is a queue: the oldest result sits on the
// result ports while empty is low and is taken when pop is high.
// Every input beat gives exactly one result beat; word_valid marks the beat
// that closes a group of 16 values or the vector (last).
// The threshold is written over cfg_valid/cfg_ready (ready is always high).
// User must write it between vectors while the block is drained (unchecked).
// Path: a taken beat is classified into the middle queue, then the packer
// writes its result into the output queue, whose oldest beat sits on the
// result ports until it is popped.
// Throughput: one beat per cycle while the receiver keeps popping, set by
// the single packer state update per cycle.
// Receiver stall: the output queue fills, the packer halts, the middle
// queue fills and full rises; nothing is dropped.
// Reset: threshold returns to 66, group and vector state clear, both
// queues empty.
// ----------------------------------------------------------------------------
module threshold_bitmap_encoder
	import tbe_pkg::*;
#(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [THR_W-1:0]         cfg_threshold,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] residual,
	output logic                     word_valid,
	output logic [WORD_W-1:0]        packed_word,
	output logic [IDX_W-1:0]         word_index,
	output logic [CNT_W-1:0]         flagged_count
);

	class_t  front_item;
	class_t  mid_item;
	result_t back_result;
	result_t out_result;
	logic    mid_full;
	logic    mid_empty;
	logic    out_full;
	logic    back_fire;

	tbe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_threshold (cfg_threshold),
		.value         (value),
		.last          (last),
		.item          (front_item)
	);

	tbe_fifo #(
		.WIDTH ($bits(class_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_item),
		.full    (mid_full),
		.rd_en   (back_fire),
		.rd_data (mid_item),
		.empty   (mid_empty)
	);

	assign full      = mid_full;
	assign back_fire = !mid_empty && !out_full;

	tbe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (back_fire),
		.item   (mid_item),
		.result (back_result)
	);

	tbe_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (back_fire),
		.wr_data (back_result),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_result),
		.empty   (empty)
	);

	assign residual      = out_result.residual;
	assign word_valid    = out_result.word_valid;
	assign packed_word   = out_result.packed_word;
	assign word_index    = out_result.word_index;
	assign flagged_count = out_result.flagged_count;

endmodule

### rtl/core/tbe_checker.sv
// ----------------------------------------------------------------------------
// Threshold bitmap encoder port checker
// Watches the result queue for group word, flag count and hold consistency.
// ----------------------------------------------------------------------------
module tbe_checker
	import tbe_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     empty,
	input logic                     pop,
	input logic signed [DATA_W-1:0] residual,
	input logic                     word_valid,
	input logic [WORD_W-1:0]        packed_word,
	input logic [IDX_W-1:0]         word_index,
	input logic [CNT_W-1:0]         flagged_count
);

	logic             have_prev_q;
	logic             prev_wv_q;
	logic [CNT_W-1:0] prev_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_wv_q   <= 1'b0;
			prev_cnt_q  <= '0;
		end else if (pop && !empty) begin
			have_prev_q <= 1'b1;
			prev_wv_q   <= word_valid;
			prev_cnt_q  <= flagged_count;
		end
	end

	// inside a group the count grows by at most one per beat
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && have_prev_q && !prev_wv_q) |->
		((flagged_count == prev_cnt_q) || (flagged_count == prev_cnt_q + 1'b1)))
		else $error("flag count jumped within a group");

	a_word_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !word_valid) |-> ((packed_word == '0) && (word_index == '0)))
		else $error("group word shown on a beat without word_valid");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (flagged_count <= MAX_FLAGS))
		else $error("flag count above its ceiling");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(residual) && $stable(flagged_count)))
		else $error("waiting result beat changed");

endmodule

bind threshold_bitmap_encoder tbe_checker u_tbe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.residual      (residual),
	.word_valid    (word_valid),
	.packed_word   (packed_word),
	.word_index    (word_index),
	.flagged_count (flagged_count)
);
